// ===== hw/rtl/code_word_handshake_sender_assert.svh =====
// ----------------------------------------------------------------------------
// code word sender assertion macros
// concurrent checks on clk, disabled while rst_n is low; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef CODE_WORD_HANDSHAKE_SENDER_ASSERT_SVH
`define CODE_WORD_HANDSHAKE_SENDER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent holds, consequent holds in the same cycle
`define CWHS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// antecedent holds, consequent holds in the next cycle
`define CWHS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`else

`define CWHS_ASSERT_IMP(label, ante, cons)
`define CWHS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/cwhs_pkg.sv =====
// ----------------------------------------------------------------------------
// code word sender package
// shared types and constants for the code word sender
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwhs_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SEND  = 4'b0010,
        PH_ACK   = 4'b0100,
        PH_DELAY = 4'b1000
    } phase_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CYCLE = 1'b1;

    localparam logic REG_KEYBOARD_MODE = 1'b0;
    localparam logic REG_SETTLE_TICKS  = 1'b1;

    localparam logic [7:0] SETTLE_RESET = 8'd7;
    localparam logic [7:0] SEP_MORE     = 8'hf0;
    localparam logic [7:0] SEP_END      = 8'hff;
    localparam logic [7:0] COUNT_MAX    = 8'hff;

    localparam logic [1:0] STATUS_MORE = 2'd0;
    localparam logic [1:0] STATUS_EOF  = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    localparam logic [1:0] LAST_BYTE = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [31:0] code_word;
        logic [7:0]  separator;
        logic        busy_line;
        logic        time_tick;
    } item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       strobe_line;
        logic       ready_res;
        logic       word_done;
        logic [1:0] word_status;
        logic       load_ignored;
    } result_t;

    typedef struct packed {
        logic       keyboard_mode;
        logic [7:0] settle_ticks;
    } cfg_t;

endpackage

// ===== hw/rtl/cwhs_if.sv =====
// ----------------------------------------------------------------------------
// code word sender channels
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cwhs_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] code_word;
    logic [7:0]  separator;
    logic        busy_line;
    logic        time_tick;

    modport source (output valid, opcode, code_word, separator, busy_line, time_tick,
                    input ready);
    modport sink (input valid, opcode, code_word, separator, busy_line, time_tick,
                  output ready);
endinterface

interface cwhs_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       strobe_line;
    logic       ready_res;
    logic       word_done;
    logic [1:0] word_status;
    logic       load_ignored;

    modport source (output valid, data_out, strobe_line, ready_res, word_done, word_status,
                    load_ignored, input ready);
    modport sink (input valid, data_out, strobe_line, ready_res, word_done, word_status,
                  load_ignored, output ready);
endinterface

interface cwhs_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cwhs_core.sv =====
// ----------------------------------------------------------------------------
// code word sender core
// word conditioning and busy/strobe sequencer, one step per accepted item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "code_word_handshake_sender_assert.svh"

module cwhs_core
    import cwhs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [31:0] word_reg, word_next;
    logic [7:0]  separator_reg, separator_next;
    logic [7:0]  delay_count_reg, delay_count_next;
    logic        strobe_reg, strobe_next;

    logic [30:0]      rest;
    logic             few_holes;
    logic [31:0]      cond_word;
    logic [7:0]       count_inc;
    logic             finish;
    logic [1:0]       status;
    logic [1:0]       byte_sel;
    logic [3:0][7:0]  word_bytes;

    always_comb
    begin
        rest      = item.code_word[30:0];
        few_holes = ((rest & (rest - 31'd1)) == 31'd0);
        if (cfg.keyboard_mode)
        begin
            cond_word = {item.code_word[31] | few_holes, rest};
        end
        else
        begin
            cond_word = {1'b0, rest};
        end
    end

    always_comb
    begin
        case (separator_reg)
            SEP_MORE: status = STATUS_MORE;
            SEP_END:  status = STATUS_EOF;
            default:  status = STATUS_BAD;
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        word_next        = word_reg;
        separator_next   = separator_reg;
        delay_count_next = delay_count_reg;
        strobe_next      = strobe_reg;
        finish           = 1'b0;
        count_inc        = delay_count_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (item.opcode == OP_LOAD)
                begin
                    word_next        = cond_word;
                    separator_next   = item.separator;
                    byte_index_next  = 2'd0;
                    delay_count_next = 8'd0;
                    strobe_next      = 1'b0;
                    phase_next       = PH_SEND;
                end
            end
            PH_SEND:
            begin
                if (!item.busy_line)
                begin
                    strobe_next = 1'b1;
                    phase_next  = PH_ACK;
                end
            end
            PH_ACK:
            begin
                if (item.busy_line)
                begin
                    strobe_next = 1'b0;
                    if (byte_index_reg == LAST_BYTE)
                    begin
                        if (cfg.keyboard_mode && (cfg.settle_ticks != 8'd0))
                        begin
                            delay_count_next = 8'd0;
                            phase_next       = PH_DELAY;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 2'd1;
                        phase_next      = PH_SEND;
                    end
                end
            end
            PH_DELAY:
            begin
                if (item.time_tick && (delay_count_reg != COUNT_MAX))
                begin
                    count_inc = delay_count_reg + 8'd1;
                end
                delay_count_next = count_inc;
                if (count_inc >= cfg.settle_ticks)
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                phase_next  = PH_IDLE;
                strobe_next = 1'b0;
            end
        endcase

        if (finish)
        begin
            phase_next       = PH_IDLE;
            byte_index_next  = 2'd0;
            delay_count_next = 8'd0;
        end
    end

    // byte 0 sits in the top bits
    always_comb
    begin
        word_bytes = word_next;
        byte_sel   = ~byte_index_next;

        if ((phase_next == PH_SEND) || (phase_next == PH_ACK))
        begin
            result.data_out = word_bytes[byte_sel];
        end
        else
        begin
            result.data_out = 8'd0;
        end
        result.strobe_line  = strobe_next;
        result.ready_res    = (phase_next == PH_IDLE);
        result.word_done    = finish;
        result.word_status  = finish ? status : STATUS_MORE;
        result.load_ignored = (item.opcode == OP_LOAD) && (phase_reg != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_index_reg  <= 2'd0;
            word_reg        <= 32'd0;
            separator_reg   <= 8'd0;
            delay_count_reg <= 8'd0;
            strobe_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            word_reg        <= word_next;
            separator_reg   <= separator_next;
            delay_count_reg <= delay_count_next;
            strobe_reg      <= strobe_next;
        end
    end

    `CWHS_ASSERT_IMP(a_strobe_only_in_ack, strobe_reg, phase_reg == PH_ACK)
    `CWHS_ASSERT_IMP(a_idle_counters_clear, phase_reg == PH_IDLE,
                     (byte_index_reg == 2'd0) && (delay_count_reg == 8'd0))
    `CWHS_ASSERT_IMP(a_delay_after_last_byte, phase_reg == PH_DELAY,
                     byte_index_reg == LAST_BYTE)

endmodule

// ===== hw/rtl/code_word_handshake_sender.sv =====
// ----------------------------------------------------------------------------
// code word handshake sender
// conditions a 32-bit code word and sends its bytes with a busy/strobe
// handshake; one result item for every input item
// ----------------------------------------------------------------------------
// item channel: one item per cycle of the parallel port; each item loads a
//   word or just samples the busy line and timer tick
// result channel: line levels, ready, done pulse and status after that item
// cfg channel: index 0 keyboard mode, index 1 settle ticks; always ready
// results reach the output register directly, or via the skid entry
// throughput: one item per cycle while results are taken; the sequencer
//   step between the state registers and the result register sets this
// a two-entry output buffer keeps taking items while one result waits;
//   with both entries full, item ready drops until the receiver takes one
// reset: sequencer idle, strobe low, buffer empty, keyboard mode 0,
//   settle ticks 7
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "code_word_handshake_sender_assert.svh"

module code_word_handshake_sender
    import cwhs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cwhs_item_if.sink     item,
    cwhs_result_if.source result,
    cwhs_cfg_if.sink      cfg
);

    cfg_t    cfg_reg;
    item_t   item_bus;
    result_t core_result;

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic item_fire;
    logic result_fire;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keyboard_mode <= 1'b0;
            cfg_reg.settle_ticks  <= SETTLE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_KEYBOARD_MODE: cfg_reg.keyboard_mode <= cfg.data[0];
                REG_SETTLE_TICKS:  cfg_reg.settle_ticks  <= cfg.data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign item_bus.opcode    = item.opcode;
    assign item_bus.code_word = item.code_word;
    assign item_bus.separator = item.separator;
    assign item_bus.busy_line = item.busy_line;
    assign item_bus.time_tick = item.time_tick;

    assign item.ready  = !skid_valid_reg;
    assign item_fire   = item.valid && item.ready;
    assign result_fire = out_valid_reg && result.ready;

    cwhs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (item_fire),
        .item   (item_bus),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (result_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (item_fire)
            begin
                out_next = core_result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (item_fire)
        begin
            if (out_valid_reg)
            begin
                skid_next       = core_result;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = core_result;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.data_out     = out_reg.data_out;
    assign result.strobe_line  = out_reg.strobe_line;
    assign result.ready_res    = out_reg.ready_res;
    assign result.word_done    = out_reg.word_done;
    assign result.word_status  = out_reg.word_status;
    assign result.load_ignored = out_reg.load_ignored;

    `CWHS_ASSERT_IMP(a_skid_behind_main, skid_valid_reg, out_valid_reg)
    `CWHS_ASSERT_NXT(a_stall_fills_skid, item_fire && out_valid_reg && !result.ready,
                     skid_valid_reg)
    `CWHS_ASSERT_NXT(a_skid_holds, skid_valid_reg && !result.ready,
                     skid_valid_reg && $stable(skid_reg))

endmodule

// ===== sim/sender_line_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code word sender line checker
// watches the item, result and register channels, steps its own copy of the
// byte sequencer for every accepted item and compares every result item
// field by field against the oldest awaited line state
// ----------------------------------------------------------------------------

module sender_line_checker
    import cwhs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    cwhs_item_if   item_ch,
    cwhs_result_if result_ch,
    cwhs_cfg_if    cfg_ch,
    output int     fail_count,
    output int     awaiting
);

    // shadow registers and sequencer state
    logic        kb_mode;
    logic [7:0]  settle_cfg;
    phase_t      seq_phase;
    logic [1:0]  byte_sel;
    logic [31:0] held_word;
    logic [7:0]  held_sep;
    logic [7:0]  tick_count;
    logic        strobe_lvl;

    result_t     awaited_lines[$];
    result_t     got;
    result_t     want;
    int          mismatches = 0;

    assign fail_count = mismatches;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic result_t step_sender(input item_t it);
        result_t    r;
        logic       finish;
        logic [1:0] status;
        r      = '0;
        finish = 1'b0;
        status = STATUS_MORE;
        r.load_ignored = (it.opcode == OP_LOAD) && (seq_phase != PH_IDLE);
        case (seq_phase)
            PH_IDLE:
            begin
                if (it.opcode == OP_LOAD)
                begin
                    held_word = it.code_word;
                    // caster drops the top bit, keyboard forces it on sparse words
                    if (!kb_mode)
                        held_word[31] = 1'b0;
                    else if ($countones(it.code_word[30:0]) < 2)
                        held_word[31] = 1'b1;
                    held_sep   = it.separator;
                    byte_sel   = '0;
                    tick_count = '0;
                    strobe_lvl = 1'b0;
                    seq_phase  = PH_SEND;
                end
            end
            PH_SEND:
            begin
                if (!it.busy_line)
                begin
                    strobe_lvl = 1'b1;
                    seq_phase  = PH_ACK;
                end
            end
            PH_ACK:
            begin
                if (it.busy_line)
                begin
                    strobe_lvl = 1'b0;
                    if (byte_sel == LAST_BYTE)
                    begin
                        if (kb_mode && settle_cfg != 8'd0)
                        begin
                            tick_count = '0;
                            seq_phase  = PH_DELAY;
                        end
                        else
                            finish = 1'b1;
                    end
                    else
                    begin
                        byte_sel  = byte_sel + 2'd1;
                        seq_phase = PH_SEND;
                    end
                end
            end
            PH_DELAY:
            begin
                if (it.time_tick && tick_count != COUNT_MAX)
                    tick_count = tick_count + 8'd1;
                if (tick_count >= settle_cfg)
                    finish = 1'b1;
            end
            default:
            begin
                seq_phase  = PH_IDLE;
                strobe_lvl = 1'b0;
            end
        endcase
        if (finish)
        begin
            if (held_sep == SEP_MORE)
                status = STATUS_MORE;
            else if (held_sep == SEP_END)
                status = STATUS_EOF;
            else
                status = STATUS_BAD;
            seq_phase  = PH_IDLE;
            byte_sel   = '0;
            tick_count = '0;
        end
        if (seq_phase == PH_SEND || seq_phase == PH_ACK)
            r.data_out = 8'(held_word >> (24 - 8 * int'(byte_sel)));
        r.strobe_line = strobe_lvl;
        r.ready_res   = (seq_phase == PH_IDLE);
        r.word_done   = finish;
        r.word_status = status;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kb_mode    <= 1'b0;
            settle_cfg <= SETTLE_RESET;
            seq_phase  <= PH_IDLE;
            byte_sel   <= '0;
            held_word  <= '0;
            held_sep   <= '0;
            tick_count <= '0;
            strobe_lvl <= 1'b0;
            awaited_lines.delete();
            awaiting   <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = {result_ch.data_out, result_ch.strobe_line, result_ch.ready_res,
                       result_ch.word_done, result_ch.word_status, result_ch.load_ignored};
                if (awaited_lines.size() == 0)
                    report("result item with nothing awaited");
                else
                begin
                    want = awaited_lines.pop_front();
                    if (got.data_out !== want.data_out)
                        report($sformatf("data_out %02h, expected %02h",
                                         got.data_out, want.data_out));
                    if (got.strobe_line !== want.strobe_line)
                        report($sformatf("strobe_line %b, expected %b",
                                         got.strobe_line, want.strobe_line));
                    if (got.ready_res !== want.ready_res)
                        report($sformatf("ready_res %b, expected %b",
                                         got.ready_res, want.ready_res));
                    if (got.word_done !== want.word_done)
                        report($sformatf("word_done %b, expected %b",
                                         got.word_done, want.word_done));
                    if (got.word_status !== want.word_status)
                        report($sformatf("word_status %0d, expected %0d",
                                         got.word_status, want.word_status));
                    if (got.load_ignored !== want.load_ignored)
                        report($sformatf("load_ignored %b, expected %b",
                                         got.load_ignored, want.load_ignored));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_KEYBOARD_MODE: kb_mode    = cfg_ch.data[0];
                    REG_SETTLE_TICKS:  settle_cfg = cfg_ch.data;
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready)
                awaited_lines.push_back(step_sender(item_t'({item_ch.opcode,
                    item_ch.code_word, item_ch.separator, item_ch.busy_line,
                    item_ch.time_tick})));
            awaiting <= awaited_lines.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code word sender testbench
// drives load and line-sampling items through a handful of register
// settings with random gaps on both sides outside the steady phases; the
// line checker beside the block predicts and compares every result item
// ----------------------------------------------------------------------------

module tb;
    import cwhs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   awaiting;
    int   cycles = 0;
    bit   steady = 1'b0;
    logic busy_level = 1'b0;

    cwhs_item_if   item_ch();
    cwhs_result_if result_ch();
    cwhs_cfg_if    cfg_ch();

    code_word_handshake_sender DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    sender_line_checker line_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ch    (item_ch),
        .result_ch  (result_ch),
        .cfg_ch     (cfg_ch),
        .fail_count (fail_count),
        .awaiting   (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver side: random stall before each result item, none when steady
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    function automatic item_t make_item(input logic op, input logic [31:0] word,
                                        input logic [7:0] sep, input logic busy,
                                        input logic tick);
        item_t it;
        it.opcode    = op;
        it.code_word = word;
        it.separator = sep;
        it.busy_line = busy;
        it.time_tick = tick;
        return it;
    endfunction

    function automatic item_t random_item(input int tick_pct);
        logic        op;
        logic [31:0] word;
        logic [7:0]  sep;
        op = ($urandom_range(0, 5) == 0) ? OP_LOAD : OP_CYCLE;
        case ($urandom_range(0, 5))
            0: word = '0;
            1: word = '1;
            2: word = 32'd1 << $urandom_range(0, 31);
            3: word = (32'd1 << $urandom_range(0, 30)) | (32'd1 << $urandom_range(0, 30));
            4: word = {1'($urandom), 31'd1 << $urandom_range(0, 30)};
            default: word = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: sep = SEP_MORE;
            1: sep = SEP_END;
            default: sep = 8'($urandom);
        endcase
        // mostly walk the busy line through the handshake
        if ($urandom_range(0, 2) != 0)
            busy_level = ~busy_level;
        return make_item(op, word, sep, busy_level, $urandom_range(0, 99) < tick_pct);
    endfunction

    task automatic push_item(input item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= it.opcode;
        item_ch.code_word <= it.code_word;
        item_ch.separator <= it.separator;
        item_ch.busy_line <= it.busy_line;
        item_ch.time_tick <= it.time_tick;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic mode, input logic [7:0] settle, input int count,
                             input int tick_pct, input bit no_gaps);
        drain();
        write_reg(REG_KEYBOARD_MODE, {7'($urandom), mode});
        write_reg(REG_SETTLE_TICKS, settle);
        steady = no_gaps;
        repeat (count)
        begin
            if ($urandom_range(0, 149) == 0)
                drain();
            push_item(random_item(tick_pct));
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.opcode    <= OP_CYCLE;
        item_ch.code_word <= '0;
        item_ch.separator <= '0;
        item_ch.busy_line <= 1'b0;
        item_ch.time_tick <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_KEYBOARD_MODE;
        cfg_ch.data       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // caster word, all ones: top bit cleared
        push_item(make_item(OP_LOAD, '1, SEP_MORE, 1'b0, 1'b0));
        push_item(make_item(OP_CYCLE, '1, SEP_END, 1'b1, 1'b1));
        push_item(make_item(OP_CYCLE, '0, '0, 1'b0, 1'b0));
        push_item(make_item(OP_CYCLE, '0, '0, 1'b0, 1'b1));
        // load while sending is dropped
        push_item(make_item(OP_LOAD, 32'h12345678, SEP_END, 1'b0, 1'b0));
        push_item(make_item(OP_CYCLE, '0, '0, 1'b1, 1'b0));
        for (int i = 0; i < 3; i++)
        begin
            push_item(make_item(OP_CYCLE, '0, '0, 1'b0, 1'b0));
            push_item(make_item(OP_CYCLE, '0, '0, 1'b1, 1'b1));
        end
        push_item(make_item(OP_CYCLE, '1, '1, 1'b1, 1'b0));
        push_item(make_item(OP_LOAD, '0, SEP_END, 1'b1, 1'b1));
        for (int i = 0; i < 4; i++)
        begin
            push_item(make_item(OP_CYCLE, '0, '0, 1'b0, 1'b1));
            push_item(make_item(OP_CYCLE, '0, '0, 1'b1, 1'b0));
        end

        run_phase(1'b0, SETTLE_RESET, 230, 50, 1'b0);
        run_phase(1'b1, 8'd0, 250, 50, 1'b1);
        run_phase(1'b1, 8'd1, 250, 50, 1'b0);
        run_phase(1'b1, 8'd255, 450, 85, 1'b0);
        run_phase(1'b1, 8'($urandom_range(2, 12)), 250, 50, 1'b1);
        run_phase(1'b0, 8'd255, 150, 50, 1'b0);
        run_phase(1'b1, 8'd3, 150, 30, 1'b0);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
